// ----- rtl/core/rdbp_pkg.sv -----
// Shared types, constants and shape tables of the radar dot and bullet plotter.
package rdbp_pkg;

    localparam int CFG_W           = 9;
    localparam int CFG_IDX_W       = 2;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CLIP_MIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_MAX_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_MIN_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_MAX_Y = 2'd3;

    localparam logic [8:0] CLIP_MIN_X_RST = 9'd0;
    localparam logic [8:0] CLIP_MAX_X_RST = 9'd287;
    localparam logic [7:0] CLIP_MIN_Y_RST = 8'd16;
    localparam logic [7:0] CLIP_MAX_Y_RST = 8'd239;

    localparam logic signed [9:0] ROW_BASE = 10'sd238;

    typedef enum logic [2:0] {
        SHP_DIAG_LR,
        SHP_DIAG_RL,
        SHP_VERT,
        SHP_HORIZ,
        SHP_DOT
    } shape_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } bk_state_t;

    typedef struct packed {
        logic [8:0] sx;
        logic [7:0] sy;
        logic [1:0] pen;
        shape_t     shape;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t data;
    } push_t;

    // Offsets per pixel in write order: {dx[1:0], dy[1:0]}, dy counts upward.
    localparam logic [3:0] DIAG_LR_OFS [0:7] = '{4'hC, 4'hD, 4'h9, 4'hA,
                                                 4'h6, 4'h7, 4'h0, 4'h0};
    localparam logic [3:0] DIAG_RL_OFS [0:7] = '{4'h4, 4'h5, 4'h9, 4'hA,
                                                 4'hE, 4'hF, 4'h0, 4'h0};
    localparam logic [3:0] VERT_OFS    [0:7] = '{4'h0, 4'h4, 4'h1, 4'h5,
                                                 4'h2, 4'h6, 4'h3, 4'h7};
    localparam logic [3:0] HORIZ_OFS   [0:7] = '{4'h1, 4'h5, 4'h0, 4'h4,
                                                 4'h9, 4'hD, 4'h8, 4'hC};
    localparam logic [3:0] DOT_OFS     [0:7] = '{4'h1, 4'h5, 4'h0, 4'h4,
                                                 4'h0, 4'h0, 4'h0, 4'h0};

    function automatic logic [2:0] shape_last_idx(input shape_t shape);
        logic [2:0] res;
        unique case (shape)
            SHP_DIAG_LR: res = 3'd5;
            SHP_DIAG_RL: res = 3'd5;
            SHP_VERT:    res = 3'd7;
            SHP_HORIZ:   res = 3'd7;
            SHP_DOT:     res = 3'd3;
            default:     res = 3'd3;
        endcase
        return res;
    endfunction

    function automatic logic [3:0] pix_offset(input shape_t shape, input logic [2:0] k);
        logic [3:0] res;
        unique case (shape)
            SHP_DIAG_LR: res = DIAG_LR_OFS[k];
            SHP_DIAG_RL: res = DIAG_RL_OFS[k];
            SHP_VERT:    res = VERT_OFS[k];
            SHP_HORIZ:   res = HORIZ_OFS[k];
            SHP_DOT:     res = DOT_OFS[k];
            default:     res = DOT_OFS[k];
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/core/radar_dot_bullet_plotter.sv -----
// Top level of the radar dot and bullet plotter.
//
// Input: an item (pos_x, pos_y, attr) is taken at a clock edge with start high
// and busy low. busy rises only while the item queue is full.
// Output: each pixel write shows on pixel_x, pixel_y, pen, last for one cycle
// with pixel_valid high; last marks the final write of an item. The receiver
// has no stall; every write is taken in the cycle it appears.
// Configuration: cfg_we, cfg_index, cfg_data write the clip window registers
// (min x, max x, min y, max y); change them only while idle.
// An accepted item passes a queue slot, the current-item register and the
// output registers before its first pixel appears. An item that fails its
// clip test writes nothing. Throughput: the emitter produces one pixel per
// cycle; a dot has four pixels, a diagonal bullet six and a straight bullet
// eight. Items of one burst follow each other with no gap; the queue lets the
// next item be taken while the current one is still drawn.
// Reset: the queue empties, no write is pending, and the clip window registers
// return to min x 0, max x 287, min y 16 and max y 239.
module radar_dot_bullet_plotter
    import rdbp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [7:0]           pos_x,
    input  logic [7:0]           pos_y,
    input  logic [3:0]           attr,
    output logic                 pixel_valid,
    output logic [8:0]           pixel_x,
    output logic [7:0]           pixel_y,
    output logic [1:0]           pen,
    output logic                 last
);

    push_t  push;
    logic   q_full;
    logic   q_nonempty;
    logic   q_pop;
    entry_t q_head;

    assign busy = q_full;

    rdbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (start && !q_full),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .attr      (attr),
        .push      (push)
    );

    rdbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    rdbp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .nonempty    (q_nonempty),
        .head        (q_head),
        .pop         (q_pop),
        .pixel_valid (pixel_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pen         (pen),
        .last        (last)
    );

endmodule

// ----- rtl/core/rdbp_front.sv -----
// Front end: clip registers, screen position, shape classification and clip test.
module rdbp_front
    import rdbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 accept,
    input  logic [7:0]           pos_x,
    input  logic [7:0]           pos_y,
    input  logic [3:0]           attr,
    output push_t                push
);

    logic [8:0] clip_min_x_reg;
    logic [8:0] clip_max_x_reg;
    logic [7:0] clip_min_y_reg;
    logic [7:0] clip_max_y_reg;

    logic [8:0]        sx;
    logic [9:0]        sx_w;
    logic [9:0]        max_x_w;
    logic signed [9:0] sy;
    logic signed [9:0] min_y_s;
    logic signed [9:0] min_y3_s;
    logic signed [9:0] max_y_s;
    logic              x_ok;
    logic              x_lt_max;
    logic              x_lt_max2;
    logic              x_lt_max3;
    logic              pass;
    shape_t            shape;
    logic [1:0]        sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_min_x_reg <= CLIP_MIN_X_RST;
            clip_max_x_reg <= CLIP_MAX_X_RST;
            clip_min_y_reg <= CLIP_MIN_Y_RST;
            clip_max_y_reg <= CLIP_MAX_Y_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLIP_MIN_X: clip_min_x_reg <= cfg_data[8:0];
                REG_CLIP_MAX_X: clip_max_x_reg <= cfg_data[8:0];
                REG_CLIP_MIN_Y: clip_min_y_reg <= cfg_data[7:0];
                REG_CLIP_MAX_Y: clip_max_y_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        sel      = attr[2:1];
        // add 256 unless attr bit 0 is set
        sx       = {~attr[0], pos_x};
        sx_w     = {1'b0, sx};
        max_x_w  = {1'b0, clip_max_x_reg};
        sy       = ROW_BASE - $signed({2'b00, pos_y});
        min_y_s  = $signed({2'b00, clip_min_y_reg});
        min_y3_s = min_y_s + 10'sd3;
        max_y_s  = $signed({2'b00, clip_max_y_reg});

        x_ok      = sx >= clip_min_x_reg;
        x_lt_max  = sx_w < max_x_w;
        x_lt_max2 = (sx_w + 10'd2) < max_x_w;
        x_lt_max3 = (sx_w + 10'd3) < max_x_w;

        if (attr[3])
        begin
            unique case (sel)
                2'd0: shape = SHP_DIAG_LR;
                2'd1: shape = SHP_DIAG_RL;
                2'd2: shape = SHP_VERT;
                default: shape = SHP_HORIZ;
            endcase
        end
        else
        begin
            shape = SHP_DOT;
        end

        unique case (shape)
            SHP_DIAG_LR,
            SHP_DIAG_RL: pass = x_ok && x_lt_max3 && (sy > min_y3_s) && (sy < max_y_s);
            SHP_VERT:    pass = x_ok && x_lt_max && (sy > min_y3_s) && (sy < max_y_s);
            SHP_HORIZ:   pass = x_ok && x_lt_max2 && (sy > min_y_s) && (sy < max_y_s);
            default:     pass = x_ok && x_lt_max && (sy > min_y_s) && (sy <= max_y_s);
        endcase

        // drop clipped items here; only drawable items reach the queue
        push.valid      = accept && pass;
        push.data.sx    = sx;
        push.data.sy    = sy[7:0];
        push.data.pen   = attr[3] ? 2'd1 : sel;
        push.data.shape = shape;
    end

endmodule

// ----- rtl/core/rdbp_queue.sv -----
// Short item queue between the front end and the pixel emitter.
module rdbp_queue
    import rdbp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    input  logic   pop,
    output logic   full,
    output logic   nonempty,
    output entry_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        full     = count_reg == CNT_FULL;
        nonempty = count_reg != '0;
        head     = slot_reg[rd_ptr_reg];
        do_push  = push.valid && !full;
        do_pop   = pop && nonempty;

        wr_ptr_next = wr_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

// ----- rtl/core/rdbp_back.sv -----
// Back end: walks the shape table of one item and emits one pixel write per cycle.
module rdbp_back
    import rdbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       nonempty,
    input  entry_t     head,
    output logic       pop,
    output logic       pixel_valid,
    output logic [8:0] pixel_x,
    output logic [7:0] pixel_y,
    output logic [1:0] pen,
    output logic       last
);

    bk_state_t  state_reg;
    bk_state_t  state_next;
    entry_t     cur_reg;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       at_last;
    logic       emit;
    logic [3:0] ofs;

    logic       pixel_valid_reg;
    logic [8:0] pixel_x_reg;
    logic [7:0] pixel_y_reg;
    logic [1:0] pen_reg;
    logic       last_reg;

    assign at_last = idx_reg == shape_last_idx(cur_reg.shape);
    assign ofs     = pix_offset(cur_reg.shape, idx_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (nonempty)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (at_last && !nonempty)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        emit     = 1'b0;
        pop      = 1'b0;
        idx_next = idx_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = nonempty;
            end
            BK_EMIT:
            begin
                emit = 1'b1;
                // chain straight into the next item on the final pixel
                pop  = at_last && nonempty;
            end
            default: ;
        endcase
        if (pop)
        begin
            idx_next = '0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pixel_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (pop)
        begin
            cur_reg <= head;
        end
        pixel_x_reg <= cur_reg.sx + {7'd0, ofs[3:2]};
        pixel_y_reg <= cur_reg.sy - {6'd0, ofs[1:0]};
        pen_reg     <= cur_reg.pen;
        last_reg    <= at_last;
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pen         = pen_reg;
    assign last        = last_reg;

endmodule

// ----- rtl/core/rdbp_checker.sv -----
// Port-level checks of the plotter and the bind that attaches them.
module rdbp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       pixel_valid,
    input logic [8:0] pixel_x,
    input logic [1:0] pen,
    input logic       last
);

    // a burst runs without gaps until its final write
    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !last |=> pixel_valid)
        else $error("pixel burst broken before last");

    // pen holds within one burst
    a_burst_pen: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !last |=> pen == $past(pen))
        else $error("pen changed inside a burst");

    // neighboring writes of one burst lie less than four columns apart
    a_burst_near: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !last |=> (pixel_x - $past(pixel_x) < 9'd4
                                  || $past(pixel_x) - pixel_x < 9'd4))
        else $error("burst pixels spread too far");

    // the queue only fills after an item was taken
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

endmodule

bind radar_dot_bullet_plotter rdbp_checker u_rdbp_checker (.*);
